@@ src/ecbs_pkg.sv @@
package ecbs_pkg;

	// field widths
	localparam int FLAG_W     = 16;
	localparam int PRESCALE_W = 16;
	localparam int QUIET_W    = 7;
	localparam int PAUSE_W    = 8;
	localparam int BEEPS_W    = 6;
	localparam int PHASE_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int NUM_SOURCES_DEF = 16;

	// register reset values
	localparam logic [PRESCALE_W-1:0] BEEP_PRESCALE_RST = 16'd100;
	localparam logic [PRESCALE_W-1:0] STEP_PRESCALE_RST = 16'd400;
	localparam logic [PRESCALE_W-1:0] PWM_LEVEL_RST     = 16'd1500;
	localparam logic [QUIET_W-1:0]    QUIET_TICKS_RST   = 7'd20;
	localparam logic [QUIET_W-1:0]    LOUD_TICKS_RST    = 7'd20;
	localparam logic [PAUSE_W-1:0]    PAUSE_TICKS_RST   = 8'd100;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BEEP_PRESCALE = 3'd0,
		REG_STEP_PRESCALE = 3'd1,
		REG_PWM_LEVEL     = 3'd2,
		REG_QUIET_TICKS   = 3'd3,
		REG_LOUD_TICKS    = 3'd4,
		REG_PAUSE_TICKS   = 3'd5
	} cfg_reg_t;

endpackage

@@ src/error_code_beep_sequencer_unit.sv @@
// Error-code beep sequencer.
// Input channel (in_valid/in_ready): one transaction per 10 ms tick, carrying
// fault_flags (bit 0 has top priority) and step_mode.
// Output channel (out_valid/out_ready): exactly one transaction per input,
// carrying the buzzer command sound_on, tone_prescale and pwm_compare.
// Step mode gives a continuous tone at step_prescale. Otherwise the lowest
// set fault bit k gives groups of k+1 beeps (quiet then loud part), each
// group followed by a silent pause. No fault: beep and pause counters
// cleared, buzzer off. Flow: the accepting edge loads the tick into the
// input register, and the edge on which the result register is free or
// being emptied updates the sequencer state and the result register.
// Throughput: one transaction per cycle while the receiver keeps taking
// results, set by the single state update per tick; the input register
// takes a new tick while a result still waits, so a stalled receiver
// blocks input only once both are full.
// Reset: asynchronous, clears the counters and the held command (silent,
// zero prescale and compare) and loads the register defaults.
// Configuration: cfg_we writes cfg_data into register cfg_index at once.
module error_code_beep_sequencer_unit
	import ecbs_pkg::*;
#(
	parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FLAG_W-1:0]     fault_flags,
	input  logic                  step_mode,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  sound_on,
	output logic [PRESCALE_W-1:0] tone_prescale,
	output logic [PRESCALE_W-1:0] pwm_compare
);

	// only this many flags take part
	localparam int LIVE_FLAGS = (NUM_SOURCES < FLAG_W) ? NUM_SOURCES : FLAG_W;
	localparam int K_W        = $clog2(FLAG_W);

	// configuration registers
	logic [PRESCALE_W-1:0] beep_prescale_q, step_prescale_q, pwm_level_q;
	logic [QUIET_W-1:0]    quiet_ticks_q, loud_ticks_q;
	logic [PAUSE_W-1:0]    pause_ticks_q;

	// input stage
	logic              valid_s1;
	logic [FLAG_W-1:0] flags_s1;
	logic              step_s1;

	// sequencer state
	logic [BEEPS_W-1:0] beeps_left_q;
	logic [PAUSE_W-1:0] pause_left_q;
	logic [PHASE_W-1:0] phase_q;
	logic               out_valid_q;
	logic               sound_q;
	logic [PRESCALE_W-1:0] prescale_q, compare_q;

	logic advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beep_prescale_q <= BEEP_PRESCALE_RST;
			step_prescale_q <= STEP_PRESCALE_RST;
			pwm_level_q     <= PWM_LEVEL_RST;
			quiet_ticks_q   <= QUIET_TICKS_RST;
			loud_ticks_q    <= LOUD_TICKS_RST;
			pause_ticks_q   <= PAUSE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BEEP_PRESCALE: beep_prescale_q <= cfg_data;
				REG_STEP_PRESCALE: step_prescale_q <= cfg_data;
				REG_PWM_LEVEL:     pwm_level_q     <= cfg_data;
				REG_QUIET_TICKS:   quiet_ticks_q   <= cfg_data[QUIET_W-1:0];
				REG_LOUD_TICKS:    loud_ticks_q    <= cfg_data[QUIET_W-1:0];
				REG_PAUSE_TICKS:   pause_ticks_q   <= cfg_data[PAUSE_W-1:0];
				default: ;
			endcase
		end
	end

	// result register free, or being emptied this cycle
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			flags_s1 <= fault_flags;
			step_s1  <= step_mode;
		end
	end

	// lowest set live flag
	logic           found;
	logic [K_W-1:0] k_idx;

	always_comb begin
		found = 1'b0;
		k_idx = '0;
		for (int i = FLAG_W - 1; i >= 0; i--) begin
			if (i < LIVE_FLAGS && flags_s1[i]) begin
				found = 1'b1;
				k_idx = K_W'(i);
			end
		end
	end

	// beep timing
	logic [PHASE_W-1:0] phase_inc, quiet_ext, beep_end;

	assign phase_inc = phase_q + PHASE_W'(1);
	assign quiet_ext = PHASE_W'(quiet_ticks_q);
	assign beep_end  = PHASE_W'(quiet_ticks_q) + PHASE_W'(loud_ticks_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beeps_left_q <= '0;
			pause_left_q <= '0;
			phase_q      <= '0;
			sound_q      <= 1'b0;
			prescale_q   <= '0;
			compare_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (valid_s1 && advance) begin
				out_valid_q <= 1'b1;
				if (step_s1) begin
					// continuous tone, counters untouched
					sound_q    <= 1'b1;
					prescale_q <= step_prescale_q;
					compare_q  <= pwm_level_q;
				end else if (!found) begin
					// phase deliberately kept
					beeps_left_q <= '0;
					pause_left_q <= '0;
					sound_q      <= 1'b0;
				end else if (beeps_left_q == '0 && pause_left_q == '0) begin
					// load a group, output held
					beeps_left_q <= BEEPS_W'(k_idx) + BEEPS_W'(1);
					pause_left_q <= pause_ticks_q;
				end else if (beeps_left_q == '0) begin
					pause_left_q <= pause_left_q - PAUSE_W'(1);
					sound_q      <= 1'b0;
				end else begin
					if (phase_inc < quiet_ext) begin
						phase_q <= phase_inc;
						sound_q <= 1'b0;
					end else if (phase_inc < beep_end) begin
						phase_q    <= phase_inc;
						sound_q    <= 1'b1;
						prescale_q <= beep_prescale_q;
						compare_q  <= pwm_level_q;
					end else begin
						// end of beep, output held
						phase_q      <= '0;
						beeps_left_q <= beeps_left_q - BEEPS_W'(1);
					end
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign sound_on      = sound_q;
	assign tone_prescale = prescale_q;
	assign pwm_compare   = compare_q;

	// a group never holds more beeps than there are live flags
	a_beeps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		beeps_left_q <= BEEPS_W'(LIVE_FLAGS))
		else $error("beep count beyond source count");

	// a held tick is not lost while the result register is stalled
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage dropped a tick");

	// step-mode tick gives the step tone
	a_step_tone: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && step_s1 && !(cfg_we) |=>
		sound_q && prescale_q == $past(step_prescale_q) && compare_q == $past(pwm_level_q))
		else $error("step tone not issued");

	// fault-free tick clears counters and silences
	a_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && !step_s1 && !found |=>
		!sound_q && beeps_left_q == '0 && pause_left_q == '0)
		else $error("fault-free tick did not clear");

endmodule
